@@ design/assert_macros.svh @@
// Assertion macros shared by the SSTF scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define SSTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SSTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/sstf_pkg.sv @@
// Shared constants for the SSTF seek scheduler.
package sstf_pkg;

  // Width of the track fields on the ports
  localparam int FIELD_W = 16;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_REQUESTS = 32;
  localparam int DEF_TRACK_BITS   = 16;

  // Entries in the queue between request intake and the scheduling engine
  localparam int QUEUE_DEPTH = 4;

endpackage

@@ design/sstf_queue.sv @@
// Small request queue that decouples request intake from the scheduling engine.
`include "assert_macros.svh"

module sstf_queue import sstf_pkg::*; #(
  parameter int W     = FIELD_W + 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;

  logic do_push;
  logic do_pop;

  assign full    = (level == LW'(DEPTH));
  assign valid   = (level != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + LW'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LW'(1);
      end
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  `SSTF_ASSERT(a_level_up, (do_push && !do_pop) |=> (level == $past(level) + LW'(1)), "queue level did not grow on push")
  `SSTF_ASSERT(a_level_max, level <= LW'(DEPTH), "queue level beyond depth")

endmodule

@@ design/sstf_back.sv @@
// Scheduling engine: sorted insert into the request store, then the SSTF service walk.
`include "assert_macros.svh"

module sstf_back import sstf_pkg::*; #(
  parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
  parameter int TRK_W        = FIELD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [TRK_W-1:0] q_track,
  input  logic             q_last,
  output logic             q_pop,
  input  logic [TRK_W-1:0] start_head,
  output logic             out_valid,
  output logic [TRK_W-1:0] out_track,
  output logic             out_last,
  output logic             out_ovf
);

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CMP  = 3'd1;
  localparam logic [2:0] S_INS_PUT  = 3'd2;
  localparam logic [2:0] S_SCAN0    = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_WALK_RD  = 3'd5;
  localparam logic [2:0] S_WALK_DEC = 3'd6;

  // Request store, kept in ascending order
  logic [TRK_W-1:0] store [MAX_REQUESTS];
  logic             we;
  logic [AW-1:0]    waddr;
  logic [TRK_W-1:0] wdata;
  logic [AW-1:0]    ra_addr;
  logic [AW-1:0]    rb_addr;
  logic [TRK_W-1:0] ra_q;
  logic [TRK_W-1:0] rb_q;

  // Control registers
  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          dropped, dropped_next;
  logic          out_valid_next;

  // Working registers
  logic [TRK_W-1:0] trk, trk_next;
  logic             is_last, is_last_next;
  logic [CW-1:0]    pos, pos_next;
  logic [TRK_W-1:0] head, head_next;
  logic [CW-1:0]    rem, rem_next;
  logic [CW-1:0]    left, left_next;
  logic             ovf, ovf_next;
  logic [CW-1:0]    idx, idx_next;
  logic [TRK_W-1:0] prev, prev_next;
  logic [TRK_W-1:0] cur, cur_next;
  logic [CW-1:0]    lp, lp_next;
  logic             lo_ok, lo_ok_next;
  logic [CW-1:0]    hp, hp_next;
  logic [TRK_W-1:0] out_track_next;
  logic             out_last_next;
  logic             out_ovf_next;

  // Distances used by the first pick and by the walk
  logic [TRK_W-1:0] first_up, first_dn;
  logic [TRK_W-1:0] walk_up, walk_dn;
  logic             hi_ok;
  logic             take_lo;

  assign first_up = ra_q - head;
  assign first_dn = head - prev;
  assign walk_up  = rb_q - cur;
  assign walk_dn  = cur - ra_q;
  assign hi_ok    = (hp != rem);
  assign take_lo  = lo_ok && (!hi_ok || (walk_up > walk_dn));

  // Next-state logic
  always_comb begin
    state_next     = state;
    count_next     = count;
    dropped_next   = dropped;
    out_valid_next = 1'b0;
    trk_next       = trk;
    is_last_next   = is_last;
    pos_next       = pos;
    head_next      = head;
    rem_next       = rem;
    left_next      = left;
    ovf_next       = ovf;
    idx_next       = idx;
    prev_next      = prev;
    cur_next       = cur;
    lp_next        = lp;
    lo_ok_next     = lo_ok;
    hp_next        = hp;
    out_track_next = out_track;
    out_last_next  = out_last;
    out_ovf_next   = out_ovf;
    we             = 1'b0;
    waddr          = pos[AW-1:0];
    wdata          = trk;
    ra_addr        = '0;
    rb_addr        = '0;
    q_pop          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          trk_next     = q_track;
          is_last_next = q_last;
          if (count == CW'(MAX_REQUESTS)) begin
            // store full: drop, but still schedule on the final request
            dropped_next = 1'b1;
            state_next   = q_last ? S_SCAN0 : S_IDLE;
          end else if (count == '0) begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = q_track;
            count_next = CW'(1);
            state_next = q_last ? S_SCAN0 : S_IDLE;
          end else begin
            pos_next   = count;
            ra_addr    = AW'(count - CW'(1));
            state_next = S_INS_CMP;
          end
        end
      end

      // shift larger entries up one place, one per cycle
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        if (ra_q > trk) begin
          wdata    = ra_q;
          pos_next = pos - CW'(1);
          if (pos == CW'(1)) begin
            state_next = S_INS_PUT;
          end else begin
            ra_addr = AW'(pos - CW'(2));
          end
        end else begin
          wdata      = trk;
          count_next = count + CW'(1);
          state_next = is_last ? S_SCAN0 : S_IDLE;
        end
      end

      S_INS_PUT: begin
        we         = 1'b1;
        waddr      = pos[AW-1:0];
        wdata      = trk;
        count_next = count + CW'(1);
        state_next = is_last ? S_SCAN0 : S_IDLE;
      end

      // take the batch and start the scan for the head position
      S_SCAN0: begin
        head_next    = start_head;
        rem_next     = count;
        ovf_next     = dropped;
        count_next   = '0;
        dropped_next = 1'b0;
        idx_next     = '0;
        ra_addr      = '0;
        state_next   = (count == '0) ? S_IDLE : S_SCAN;
      end

      // first entry at or above the head; pick it or its lower neighbor
      S_SCAN: begin
        if ((ra_q >= head) || (idx + CW'(1) == rem)) begin
          if ((ra_q >= head) && (idx != '0) && !(first_up < first_dn)) begin
            out_track_next = prev;
            cur_next       = prev;
            lo_ok_next     = (idx != CW'(1));
            lp_next        = idx - CW'(2);
            hp_next        = idx;
          end else begin
            out_track_next = ra_q;
            cur_next       = ra_q;
            lo_ok_next     = (idx != '0);
            lp_next        = idx - CW'(1);
            hp_next        = idx + CW'(1);
          end
          out_valid_next = 1'b1;
          out_last_next  = (rem == CW'(1));
          out_ovf_next   = ovf;
          left_next      = rem - CW'(1);
          state_next     = (rem == CW'(1)) ? S_IDLE : S_WALK_RD;
        end else begin
          prev_next = ra_q;
          idx_next  = idx + CW'(1);
          ra_addr   = AW'(idx + CW'(1));
        end
      end

      // fetch both remaining neighbors
      S_WALK_RD: begin
        ra_addr    = lp[AW-1:0];
        rb_addr    = hp[AW-1:0];
        state_next = S_WALK_DEC;
      end

      // serve the nearer neighbor, ties go up
      S_WALK_DEC: begin
        if (take_lo) begin
          out_track_next = ra_q;
          cur_next       = ra_q;
          lo_ok_next     = (lp != '0);
          lp_next        = lp - CW'(1);
        end else begin
          out_track_next = rb_q;
          cur_next       = rb_q;
          hp_next        = hp + CW'(1);
        end
        out_valid_next = 1'b1;
        out_last_next  = (left == CW'(1));
        out_ovf_next   = ovf;
        left_next      = left - CW'(1);
        state_next     = (left == CW'(1)) ? S_IDLE : S_WALK_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Store write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    ra_q <= store[ra_addr];
    rb_q <= store[rb_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    trk       <= trk_next;
    is_last   <= is_last_next;
    pos       <= pos_next;
    head      <= head_next;
    rem       <= rem_next;
    left      <= left_next;
    ovf       <= ovf_next;
    idx       <= idx_next;
    prev      <= prev_next;
    cur       <= cur_next;
    lp        <= lp_next;
    lo_ok     <= lo_ok_next;
    hp        <= hp_next;
    out_track <= out_track_next;
    out_last  <= out_last_next;
    out_ovf   <= out_ovf_next;
  end

  `SSTF_ASSERT(a_emit_src, out_valid |-> ($past(state) == S_SCAN || $past(state) == S_WALK_DEC), "result strobe outside the service walk")
  `SSTF_ASSERT(a_last_idle, (out_valid && out_last) |-> (state == S_IDLE), "engine still busy after the final result")
  `SSTF_ASSERT(a_pop_idle, q_pop |-> (state == S_IDLE && q_valid), "request taken outside idle")
  `SSTF_ASSERT(a_count_max, count <= CW'(MAX_REQUESTS), "request count beyond store depth")

endmodule

@@ design/sstf_seek_scheduler.sv @@
// Top level: request intake, start_head register, queue and scheduling engine.
// Request load: an accepted request enters the queue; the engine takes it from the queue when idle
//   and inserts it in sorted order, shifting each larger stored entry up one place.
// Batch output: after the final request is inserted, a setup step (S_SCAN0) and a scan of the
//   sorted requests find the head position; then one result per S_WALK_RD/S_WALK_DEC pair.
// busy is high only while the 4-entry intake queue is full; results cannot be stalled.
// Reset clears the queue, request count, drop flag and start_head; the store is not cleared.
module sstf_seek_scheduler import sstf_pkg::*; #(
  parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
  parameter int TRACK_BITS   = DEF_TRACK_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] track,
  input  logic               last_request,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FIELD_W-1:0] cfg_data,
  output logic               result_valid,
  output logic [FIELD_W-1:0] served_track,
  output logic               last_served,
  output logic               overflow
);

  // Internal track width: the port width bounds the value range
  localparam int TW = (TRACK_BITS < FIELD_W) ? TRACK_BITS : FIELD_W;

  logic [FIELD_W-1:0] start_head;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic [TW:0]        q_rdata;
  logic [TW-1:0]      back_track;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_head <= cfg_data;
    end
  end

  // Intake: accept while the queue has room, mask the track to its range
  assign busy = q_full;
  assign push = start && !busy;

  sstf_queue #(
    .W     (TW + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({last_request, track[TW-1:0]}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  sstf_back #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRK_W        (TW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_track    (q_rdata[TW-1:0]),
    .q_last     (q_rdata[TW]),
    .q_pop      (q_pop),
    .start_head (start_head[TW-1:0]),
    .out_valid  (result_valid),
    .out_track  (back_track),
    .out_last   (last_served),
    .out_ovf    (overflow)
  );

  assign served_track = FIELD_W'(back_track);

endmodule

@@ dv/sstf_seek_scheduler_tb.sv @@
// Self-checking testbench for the SSTF seek scheduler: directed table, then random batches.
`timescale 1ns / 1ps

module sstf_seek_scheduler_tb;
  import sstf_pkg::*;

  localparam int MAX_REQ       = DEF_MAX_REQUESTS;
  localparam int RANDOM_ITEMS  = 300;
  // Enough for a full intake queue of worst-case sorted inserts to finish
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int N_ROWS        = 21;

  // One served request as seen on the result ports
  typedef struct packed {
    logic [FIELD_W-1:0] trk;
    logic               fin;
    logic               ovf;
  } service_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // Directed row: a request, or a start_head write; typed rows carry their single result
  typedef struct packed {
    row_kind_t          kind;
    logic [FIELD_W-1:0] val;
    logic               fin;
    logic               typed;
    logic [FIELD_W-1:0] exp_trk;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [FIELD_W-1:0] track = '0;
  logic               last_request = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic               result_valid;
  logic [FIELD_W-1:0] served_track;
  logic               last_served;
  logic               overflow;

  // Predictor state and the results still owed by the block
  logic [FIELD_W-1:0] stored_tracks[$];
  bit                 batch_dropped;
  logic [FIELD_W-1:0] head_track;
  service_t           expected_service[$];

  int fail_count  = 0;
  int cycle_count = 0;
  int burst_left  = 0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_REQ, 16'h0000, 1'b1, 1'b1, 16'h0000},
    '{ROW_REQ, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
    '{ROW_REQ, 16'hA5A5, 1'b1, 1'b1, 16'hA5A5},
    '{ROW_REQ, 16'h5A5A, 1'b1, 1'b1, 16'h5A5A},
    '{ROW_REQ, 16'd300,  1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'd100,  1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'd200,  1'b1, 1'b0, 16'd0},
    '{ROW_CFG, 16'd1000, 1'b0, 1'b0, 16'd0},
    // equal distance on the first pick
    '{ROW_REQ, 16'd990,  1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'd1010, 1'b1, 1'b0, 16'd0},
    // equal distance to both neighbors after the first service
    '{ROW_REQ, 16'd1000, 1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'd900,  1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'd1100, 1'b1, 1'b0, 16'd0},
    // duplicate tracks
    '{ROW_REQ, 16'd7,    1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'd7,    1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'd7,    1'b1, 1'b0, 16'd0},
    '{ROW_CFG, 16'hFFFF, 1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'h0000, 1'b0, 1'b0, 16'd0},
    '{ROW_REQ, 16'hFFFF, 1'b1, 1'b0, 16'd0},
    '{ROW_REQ, 16'h8000, 1'b1, 1'b1, 16'h8000},
    '{ROW_CFG, 16'h0000, 1'b0, 1'b0, 16'd0}
  };

  sstf_seek_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .track        (track),
    .last_request (last_request),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .served_track (served_track),
    .last_served  (last_served),
    .overflow     (overflow)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Append one owed result at the tail of the expectation queue
  function automatic void add_expected(input service_t rec);
    expected_service.insert(expected_service.size(), rec);
  endfunction

  // Sorted insert of one request; on the final one, queue the batch in SSTF order
  function automatic void take_request(input logic [FIELD_W-1:0] t, input bit fin,
                                       input bit quiet);
    logic [FIELD_W-1:0] order[$];
    service_t rec;
    bit ovf;
    int pos, idx, nxt, best, d, up, dn;
    if (stored_tracks.size() >= MAX_REQ) begin
      batch_dropped = 1'b1;
    end else begin
      pos = stored_tracks.size();
      while (pos > 0 && stored_tracks[pos-1] > t) pos--;
      stored_tracks.insert(pos, t);
    end
    if (!fin) return;
    order = stored_tracks;
    ovf = batch_dropped;
    stored_tracks.delete();
    batch_dropped = 1'b0;
    if (order.size() == 0) return;
    // first pick: nearest to the head, lower track on a tie
    idx = 0;
    best = int'(order[0]) - int'(head_track);
    if (best < 0) best = -best;
    for (int i = 1; i < order.size(); i++) begin
      d = int'(order[i]) - int'(head_track);
      if (d < 0) d = -d;
      if (d < best) begin
        best = d;
        idx = i;
      end
    end
    // walk the sorted neighbors, higher track on a tie
    while (1) begin
      rec.trk = order[idx];
      rec.fin = (order.size() == 1);
      rec.ovf = ovf;
      if (!quiet) add_expected(rec);
      if (order.size() == 1) break;
      if (idx == 0) begin
        nxt = 0;
      end else if (idx == order.size() - 1) begin
        nxt = idx - 1;
      end else begin
        up = int'(order[idx+1]) - int'(order[idx]);
        dn = int'(order[idx]) - int'(order[idx-1]);
        nxt = (up > dn) ? idx - 1 : idx;
      end
      order.delete(idx);
      idx = nxt;
    end
  endfunction

  // One request transfer, with bursts of back-to-back items and random gaps between
  task automatic drive_request(input logic [FIELD_W-1:0] t, input bit fin, input bit quiet);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start        <= 1'b1;
    track        <= t;
    last_request <= fin;
    do @(posedge clk); while (busy);
    take_request(t, fin, quiet);
  endtask

  // Hold off until every owed result has come and the intake has settled
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_service.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_head(input logic [FIELD_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    head_track = v;
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    service_t want;
    if (!rst && result_valid) begin
      if (expected_service.size() == 0) begin
        $error("unexpected result: served_track %0d", served_track);
        fail_count++;
      end else begin
        want = expected_service.pop_front();
        if (served_track !== want.trk) begin
          $error("served_track: expected %0d, actual %0d", want.trk, served_track);
          fail_count++;
        end
        if (last_served !== want.fin) begin
          $error("last_served: expected %0d, actual %0d", want.fin, last_served);
          fail_count++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow: expected %0d, actual %0d", want.ovf, overflow);
          fail_count++;
        end
      end
    end
  end

  initial begin
    service_t rec;
    int items_sent, phase, n_batches, len, mode, pick;
    logic [FIELD_W-1:0] base, step, t;

    stored_tracks.delete();
    batch_dropped = 1'b0;
    head_track = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_start_head(directed_rows[i].val);
      end else begin
        drive_request(directed_rows[i].val, directed_rows[i].fin, directed_rows[i].typed);
        if (directed_rows[i].typed) begin
          rec.trk = directed_rows[i].exp_trk;
          rec.fin = 1'b1;
          rec.ovf = 1'b0;
          add_expected(rec);
        end
      end
    end

    // Random phases: a start_head setting, then a few whole batches
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase % 5)
        0:       write_start_head(16'hFFFF);
        1:       write_start_head(16'h0000);
        2:       write_start_head(16'($urandom));
        3:       write_start_head(16'h8000);
        default: write_start_head(16'($urandom_range(0, 255)));
      endcase
      n_batches = $urandom_range(2, 4);
      repeat (n_batches) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      len = MAX_REQ + 1;         // final request dropped
        else if (pick == 1) len = $urandom_range(MAX_REQ, MAX_REQ + 8);
        else if (pick < 5)  len = $urandom_range(9, MAX_REQ - 1);
        else                len = $urandom_range(1, 8);
        mode = $urandom_range(0, 2);
        base = 16'($urandom);
        step = 16'($urandom_range(1, 40));
        for (int k = 0; k < len; k++) begin
          case (mode)
            0:       t = 16'($urandom);
            // near the head, so distance ties are common
            1:       t = head_track + 16'($urandom_range(0, 64)) - 16'd32;
            // a few evenly spaced tracks with repeats
            default: t = base + step * 16'($urandom_range(0, 7));
          endcase
          drive_request(t, k == len - 1, 1'b0);
          items_sent++;
        end
      end
      phase++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
